// ===== src/srls_pkg.sv =====
`timescale 1ns / 1ps
package srls_pkg;

  localparam int unsigned ROW_BITS = 10;
  localparam int unsigned IDX_BITS = 11;
  localparam int unsigned OUT_PTR_BITS = 24;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_FETCH = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic ins_shift;
    logic ins_place;
    logic rd_fetch;
    logic fetch_pop;
    logic fetch_empty;
  } srls_cmd_t;

  typedef struct packed {
    logic ins_go;
    logic pos_zero;
    logic rd_less;
    logic empty;
  } srls_sts_t;

endpackage

// ===== src/sparse_row_length_sorter.sv =====
`timescale 1ns / 1ps
// clear, base load and dropped load: busy stays low
// load with insertion: k = rows shifted past (at most the fill level); busy through ST_INS_CHK
// and ST_INS_CMP per shifted row, ending in ST_INS_CHK at the store head, else in ST_INS_CMP
// fetch: result strobe in the cycle after accept if empty, else after the store read
// reset is asynchronous and clears control state only; the store needs no clearing pass
module sparse_row_length_sorter #(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned POINTER_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [23:0] row_pointer_i,
  output logic        done_o,
  output logic        valid_res_o,
  output logic [9:0]  original_row_o,
  output logic [23:0] row_length_o,
  output logic [23:0] new_row_start_o,
  output logic        last_row_o,
  output logic        overflow_o,
  output logic        bad_pointer_o
);
  import srls_pkg::*;

  srls_cmd_t cmd;
  srls_sts_t sts;

  srls_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .opcode_i(opcode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  srls_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .POINTER_BITS(POINTER_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_pointer_i  (row_pointer_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .valid_res_o    (valid_res_o),
    .original_row_o (original_row_o),
    .row_length_o   (row_length_o),
    .new_row_start_o(new_row_start_o),
    .last_row_o     (last_row_o),
    .overflow_o     (overflow_o),
    .bad_pointer_o  (bad_pointer_o)
  );

`ifndef NO_ASSERTIONS
  a_pop_via_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && valid_res_o |-> $past(busy_o))
    else $error("row returned without a store read");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !valid_res_o |-> last_row_o && (row_length_o == '0) && (original_row_o == '0))
    else $error("empty fetch result malformed");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && valid_res_o |=> !(done_o && valid_res_o))
    else $error("two row results in consecutive cycles");
`endif

endmodule

// ===== src/srls_ram.sv =====
`timescale 1ns / 1ps
module srls_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/srls_ctrl.sv =====
`timescale 1ns / 1ps
module srls_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        opcode_i,
  input  srls_pkg::srls_sts_t sts_i,
  output srls_pkg::srls_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import srls_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_FT_OUT
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_e'(opcode_i))
            OP_CLEAR: cmd_o.clear = 1'b1;
            OP_LOAD: begin
              cmd_o.load = 1'b1;
              if (sts_i.ins_go) state_d = ST_INS_CHK;
            end
            OP_FETCH: begin
              if (sts_i.empty) begin
                cmd_o.fetch_empty = 1'b1;
                done_d = 1'b1;
              end else begin
                cmd_o.rd_fetch = 1'b1;
                state_d = ST_FT_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INS_CHK: begin
        if (sts_i.pos_zero) begin
          cmd_o.ins_place = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        // shorter row moves one place towards the tail
        if (sts_i.rd_less) begin
          cmd_o.ins_shift = 1'b1;
          state_d = ST_INS_CHK;
        end else begin
          cmd_o.ins_place = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FT_OUT: begin
        cmd_o.fetch_pop = 1'b1;
        done_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

// ===== src/srls_dp.sv =====
`timescale 1ns / 1ps
module srls_dp #(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned POINTER_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [23:0]         row_pointer_i,
  input  srls_pkg::srls_cmd_t cmd_i,
  output srls_pkg::srls_sts_t sts_o,
  output logic                valid_res_o,
  output logic [9:0]          original_row_o,
  output logic [23:0]         row_length_o,
  output logic [23:0]         new_row_start_o,
  output logic                last_row_o,
  output logic                overflow_o,
  output logic                bad_pointer_o
);
  import srls_pkg::*;

  localparam int unsigned PW = POINTER_BITS;
  localparam int unsigned AW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned EW = PW + ROW_BITS;

  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic [PW-1:0]       new_len_q, new_len_d;
  logic [ROW_BITS-1:0] new_row_q, new_row_d;
  logic [IDX_BITS-1:0] next_row_q, next_row_d;
  logic [PW-1:0]       prev_q, prev_d;
  logic                have_base_q, have_base_d;
  logic [PW-1:0]       run_q, run_d;
  logic                ovf_q, ovf_d;
  logic                bad_q, bad_d;

  logic [31:0]   ptr_w;
  logic [PW-1:0] ptr;
  logic [PW:0]   sum;
  logic          full;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [PW-1:0] rd_len;
  logic [ROW_BITS-1:0] rd_row;
  logic [31:0]   len_w, run_w;

  logic                res_valid_q;
  logic [ROW_BITS-1:0] res_row_q;
  logic [23:0]         res_len_q, res_start_q;
  logic                res_last_q, res_ovf_q, res_bad_q;

  assign ptr_w  = {8'd0, row_pointer_i};
  assign ptr    = ptr_w[PW-1:0];
  assign full   = (count_q >= CW'(MAX_ROWS));
  assign rd_len = rdata[EW-1:ROW_BITS];
  assign rd_row = rdata[ROW_BITS-1:0];
  assign sum    = {1'b0, run_q} + {1'b0, rd_len};
  assign len_w  = 32'(rd_len);
  assign run_w  = 32'(run_q);

  assign sts_o.ins_go   = have_base_q && !full;
  assign sts_o.pos_zero = (pos_q == '0);
  assign sts_o.rd_less  = (rd_len < new_len_q);
  assign sts_o.empty    = (count_q == '0);

  // circular store: head is the longest row, insertion walks back from the tail
  assign raddr = cmd_i.rd_fetch ? head_q : AW'(head_q + AW'(pos_q) - AW'(1));
  assign waddr = AW'(head_q + AW'(pos_q));
  assign we    = cmd_i.ins_shift || cmd_i.ins_place;
  assign wdata = cmd_i.ins_shift ? rdata : {new_len_q, new_row_q};

  srls_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    pos_d       = pos_q;
    new_len_d   = new_len_q;
    new_row_d   = new_row_q;
    next_row_d  = next_row_q;
    prev_d      = prev_q;
    have_base_d = have_base_q;
    run_d       = run_q;
    ovf_d       = ovf_q;
    bad_d       = bad_q;
    if (cmd_i.clear) begin
      head_d      = '0;
      count_d     = '0;
      pos_d       = '0;
      next_row_d  = '0;
      prev_d      = '0;
      have_base_d = 1'b0;
      run_d       = '0;
      ovf_d       = 1'b0;
      bad_d       = 1'b0;
    end
    if (cmd_i.load) begin
      prev_d = ptr;
      if (!have_base_q) begin
        have_base_d = 1'b1;
      end else begin
        if (ptr >= prev_q) begin
          new_len_d = ptr - prev_q;
        end else begin
          new_len_d = '0;
          bad_d = 1'b1;
        end
        new_row_d  = next_row_q[ROW_BITS-1:0];
        next_row_d = next_row_q + IDX_BITS'(1);
        pos_d      = count_q;
        if (full) ovf_d = 1'b1;
      end
    end
    if (cmd_i.ins_shift) pos_d = pos_q - CW'(1);
    if (cmd_i.ins_place) count_d = count_q + CW'(1);
    if (cmd_i.fetch_pop) begin
      head_d  = head_q + AW'(1);
      count_d = count_q - CW'(1);
      run_d   = sum[PW] ? {PW{1'b1}} : sum[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      next_row_q  <= '0;
      prev_q      <= '0;
      have_base_q <= 1'b0;
      run_q       <= '0;
      ovf_q       <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      next_row_q  <= next_row_d;
      prev_q      <= prev_d;
      have_base_q <= have_base_d;
      run_q       <= run_d;
      ovf_q       <= ovf_d;
      bad_q       <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_len_q <= new_len_d;
    new_row_q <= new_row_d;
    if (cmd_i.fetch_empty) begin
      res_valid_q <= 1'b0;
      res_row_q   <= '0;
      res_len_q   <= '0;
      res_start_q <= '0;
      res_last_q  <= 1'b1;
      res_ovf_q   <= ovf_q;
      res_bad_q   <= bad_q;
    end else if (cmd_i.fetch_pop) begin
      res_valid_q <= 1'b1;
      res_row_q   <= rd_row;
      res_len_q   <= len_w[23:0];
      res_start_q <= run_w[23:0];
      res_last_q  <= (count_q == CW'(1));
      res_ovf_q   <= ovf_q;
      res_bad_q   <= bad_q;
    end
  end

  assign valid_res_o     = res_valid_q;
  assign original_row_o  = res_row_q;
  assign row_length_o    = res_len_q;
  assign new_row_start_o = res_start_q;
  assign last_row_o      = res_last_q;
  assign overflow_o      = res_ovf_q;
  assign bad_pointer_o   = res_bad_q;

endmodule

// ===== test/tb_sparse_row_length_sorter.sv =====
`timescale 1ns / 1ps
module tb_sparse_row_length_sorter;
  import srls_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct {
    opcode_e     op;
    logic [23:0] ptr;
  } command_t;

  typedef struct {
    logic        valid;
    logic [9:0]  row;
    logic [23:0] len;
    logic [23:0] start;
    logic        last;
    logic        ovf;
    logic        bad;
  } fetch_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  opcode_i = OP_NONE;
  logic [23:0] row_pointer_i = '0;
  logic        busy_o;
  logic        done_o;
  logic        valid_res_o;
  logic [9:0]  original_row_o;
  logic [23:0] row_length_o;
  logic [23:0] new_row_start_o;
  logic        last_row_o;
  logic        overflow_o;
  logic        bad_pointer_o;

  sparse_row_length_sorter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .row_pointer_i   (row_pointer_i),
    .done_o          (done_o),
    .valid_res_o     (valid_res_o),
    .original_row_o  (original_row_o),
    .row_length_o    (row_length_o),
    .new_row_start_o (new_row_start_o),
    .last_row_o      (last_row_o),
    .overflow_o      (overflow_o),
    .bad_pointer_o   (bad_pointer_o)
  );

  command_t      pending_cmds[$];
  fetch_result_t expected_fetches[$];
  int            error_count = 0;
  int            stall_cycles = 0;
  int            gap_left = 0;

  // sorted row store, longest first, ties in load order
  logic [23:0] store_len[DEPTH];
  logic [10:0] store_row[DEPTH];
  int unsigned store_fill;
  logic [10:0] row_index;
  logic [23:0] prev_ptr;
  logic        base_seen;
  logic [23:0] run_start;
  logic        ovf_flag;
  logic        bad_flag;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_store();
    store_fill = 0;
    row_index = '0;
    prev_ptr = '0;
    base_seen = 1'b0;
    run_start = '0;
    ovf_flag = 1'b0;
    bad_flag = 1'b0;
  endtask

  task automatic apply_command(command_t c);
    logic [23:0]   len;
    int            pos;
    fetch_result_t r;
    logic [24:0]   sum;
    case (c.op)
      OP_CLEAR: clear_store();
      OP_LOAD: begin
        if (!base_seen) begin
          prev_ptr = c.ptr;
          base_seen = 1'b1;
        end else begin
          if (c.ptr >= prev_ptr) begin
            len = c.ptr - prev_ptr;
          end else begin
            len = '0;
            bad_flag = 1'b1;
          end
          prev_ptr = c.ptr;
          if (store_fill >= DEPTH) begin
            ovf_flag = 1'b1;
          end else begin
            pos = store_fill;
            while (pos > 0 && store_len[pos-1] < len) begin
              store_len[pos] = store_len[pos-1];
              store_row[pos] = store_row[pos-1];
              pos--;
            end
            store_len[pos] = len;
            store_row[pos] = row_index;
            store_fill++;
          end
          row_index = row_index + 11'd1;
        end
      end
      OP_FETCH: begin
        if (store_fill == 0) begin
          r.valid = 1'b0;
          r.row = '0;
          r.len = '0;
          r.start = '0;
          r.last = 1'b1;
        end else begin
          r.valid = 1'b1;
          r.row = store_row[0][9:0];
          r.len = store_len[0];
          r.start = run_start;
          sum = {1'b0, run_start} + {1'b0, store_len[0]};
          run_start = sum[24] ? 24'hFFFFFF : sum[23:0];
          for (int i = 1; i < store_fill; i++) begin
            store_len[i-1] = store_len[i];
            store_row[i-1] = store_row[i];
          end
          store_fill--;
          r.last = (store_fill == 0);
        end
        r.ovf = ovf_flag;
        r.bad = bad_flag;
        expected_fetches.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("error at %0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, want);
    error_count++;
  endtask

  task automatic push_cmd(opcode_e op, logic [23:0] ptr);
    command_t c;
    c.op = op;
    c.ptr = ptr;
    pending_cmds.push_back(c);
  endtask

  // driver
  always @(posedge clk_i) begin
    logic accepted;
    accepted = start_i && !busy_o;
    if (accepted) begin
      apply_command(pending_cmds.pop_front());
    end
    if (rst_ni && (!start_i || accepted)) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_cmds.size() > 150 && $urandom_range(0, 11) == 0) begin
        gap_left = $urandom_range(0, 15);
        start_i <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        start_i <= 1'b1;
        opcode_i <= pending_cmds[0].op;
        row_pointer_i <= pending_cmds[0].ptr;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    fetch_result_t w;
    if (done_o) begin
      if (expected_fetches.size() == 0) begin
        report_mismatch("unexpected result transaction", 1, 0);
      end else begin
        w = expected_fetches.pop_front();
        if (valid_res_o !== w.valid) report_mismatch("valid_res", valid_res_o, w.valid);
        if (original_row_o !== w.row) report_mismatch("original_row", original_row_o, w.row);
        if (row_length_o !== w.len) report_mismatch("row_length", row_length_o, w.len);
        if (new_row_start_o !== w.start)
          report_mismatch("new_row_start", new_row_start_o, w.start);
        if (last_row_o !== w.last) report_mismatch("last_row", last_row_o, w.last);
        if (overflow_o !== w.ovf) report_mismatch("overflow", overflow_o, w.ovf);
        if (bad_pointer_o !== w.bad) report_mismatch("bad_pointer", bad_pointer_o, w.bad);
      end
    end
    if (done_o || (start_i && !busy_o)) begin
      stall_cycles = 0;
    end else if (rst_ni) begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [23:0] ptr;
    int          rows;
    int          sel;
    clear_store();

    // directed: empty fetch, decreasing pointer, ties, saturation, unknown opcode
    push_cmd(OP_FETCH, 24'h0);
    push_cmd(OP_LOAD, 24'h0);
    push_cmd(OP_LOAD, 24'h5);
    push_cmd(OP_LOAD, 24'h5);
    push_cmd(OP_LOAD, 24'h3);
    push_cmd(OP_LOAD, 24'hFFFFFF);
    push_cmd(OP_LOAD, 24'hFFFFFF);
    push_cmd(OP_NONE, 24'hFFFFFF);
    push_cmd(OP_LOAD, 24'h000002);
    push_cmd(OP_LOAD, 24'hFFFFF0);
    push_cmd(OP_LOAD, 24'hFFFFF5);
    for (int i = 0; i < 8; i++) push_cmd(OP_FETCH, 24'h0);
    push_cmd(OP_CLEAR, 24'hABCDEF);
    push_cmd(OP_FETCH, 24'h0);

    // fill past capacity with equal lengths
    push_cmd(OP_LOAD, 24'h100);
    for (int i = 1; i <= 1030; i++) push_cmd(OP_LOAD, 24'h100 + 24'(i * 3));
    for (int i = 0; i < 6; i++) push_cmd(OP_FETCH, 24'h0);
    push_cmd(OP_LOAD, 24'h100 + 24'(1030 * 3) + 24'd40);
    push_cmd(OP_LOAD, 24'h100 + 24'(1030 * 3) + 24'd40);
    for (int i = 0; i < 4; i++) push_cmd(OP_FETCH, 24'h0);
    push_cmd(OP_CLEAR, 24'h0);

    // random row sets (some with decreasing pointers) plus some noise
    for (int n = 0; n < 600; ) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        push_cmd(OP_NONE, 24'($urandom));
        n++;
      end else if (sel == 1) begin
        push_cmd(OP_FETCH, 24'($urandom));
        n++;
      end else begin
        if (sel > 4) begin
          push_cmd(OP_CLEAR, 24'($urandom));
          n++;
        end
        ptr = 24'($urandom);
        push_cmd(OP_LOAD, ptr);
        rows = $urandom_range(1, 24);
        for (int i = 0; i < rows; i++) begin
          case ($urandom_range(0, 9))
            0: ptr = 24'($urandom);
            1: ptr = ptr - 24'($urandom_range(1, 1000));
            2: ;
            default: ptr = ptr + 24'($urandom_range(0, 60));
          endcase
          push_cmd(OP_LOAD, ptr);
          if ($urandom_range(0, 7) == 0) push_cmd(OP_FETCH, 24'($urandom));
        end
        for (int i = 0; i < rows + int'($urandom_range(0, 2)); i++)
          push_cmd(OP_FETCH, 24'($urandom));
        n += 2 * rows + 1;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (pending_cmds.size() != 0 || expected_fetches.size() != 0);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
